@@ src/fqs_pkg.sv @@
package fqs_pkg;

   localparam int DEPTH      = 16;
   localparam int DATA_WIDTH = 32;

   localparam int IDX_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int SUM_W = IDX_W + 1;
   localparam int POS_W = 8;
   localparam int CMP_W = (POS_W > CNT_W) ? POS_W : CNT_W;

   localparam logic [1:0] OP_ENQUEUE = 2'd0;
   localparam logic [1:0] OP_DEQUEUE = 2'd1;
   localparam logic [1:0] OP_SEARCH  = 2'd2;
   localparam logic [1:0] OP_READ    = 2'd3;

   localparam logic [1:0] STATUS_OK      = 2'd0;
   localparam logic [1:0] STATUS_EMPTY   = 2'd1;
   localparam logic [1:0] STATUS_FULL    = 2'd2;
   localparam logic [1:0] STATUS_BAD_POS = 2'd3;

   typedef struct packed {
      logic [1:0]         operation;
      logic signed [31:0] value;
      logic [POS_W-1:0]   position;
   } req_type;

   typedef struct packed {
      logic [1:0]         status;
      logic               found;
      logic signed [31:0] read_data;
      logic               is_empty;
      logic [4:0]         occupancy;
   } rsp_type;

   typedef struct packed {
      logic    valid;
      rsp_type data;
   } push_type;

   typedef struct packed {
      logic                  wr_en;
      logic [IDX_W-1:0]      wr_addr;
      logic [DATA_WIDTH-1:0] wr_data;
      logic                  rd_en;
      logic [IDX_W-1:0]      rd_addr;
   } ram_req_type;

   function automatic logic [IDX_W-1:0] slot_at(logic [IDX_W-1:0] head,
                                                logic [IDX_W-1:0] offset);
      logic [SUM_W-1:0] s;
      s = {1'b0, head} + {1'b0, offset};
      if (s >= SUM_W'(DEPTH)) begin
         s = s - SUM_W'(DEPTH);
      end
      return s[IDX_W-1:0];
   endfunction

   function automatic logic [IDX_W-1:0] next_slot(logic [IDX_W-1:0] slot);
      logic [IDX_W-1:0] n;
      if (slot == IDX_W'(DEPTH - 1)) begin
         n = '0;
      end else begin
         n = slot + 1'b1;
      end
      return n;
   endfunction

   function automatic logic [DATA_WIDTH-1:0] to_word(logic signed [31:0] v);
      return DATA_WIDTH'(v);
   endfunction

   function automatic logic signed [31:0] to_out(logic [DATA_WIDTH-1:0] w);
      return $signed(32'(w));
   endfunction

endpackage

@@ src/fqs_ram.sv @@
module fqs_ram
   import fqs_pkg::*;
(
   input  logic                  clock,
   input  ram_req_type           ram_req,
   output logic [DATA_WIDTH-1:0] rd_data
);

   logic [DATA_WIDTH-1:0] mem [DEPTH];
   logic [DATA_WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (ram_req.wr_en) begin
         mem[ram_req.wr_addr] <= ram_req.wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (ram_req.rd_en) begin
         rd_data_ff <= mem[ram_req.rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ src/fqs_ctrl.sv @@
module fqs_ctrl
   import fqs_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  req_type               req_data,
   input  logic                  out_free,
   output push_type              push,
   output ram_req_type           ram_req,
   input  logic [DATA_WIDTH-1:0] rd_data
);

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_READ   = 4'b0010,
      ST_SEARCH = 4'b0100,
      ST_DONE   = 4'b1000
   } state_type;

   state_type             state_ff, state_in;
   logic [IDX_W-1:0]      head_ff, head_in;
   logic [IDX_W-1:0]      tail_ff, tail_in;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic [CNT_W-1:0]      scan_ff, scan_in;
   logic                  cmp_vld_ff, cmp_vld_in;
   logic                  found_ff, found_in;
   logic [DATA_WIDTH-1:0] val_ff, val_in;
   rsp_type               res_ff, res_in;
   logic                  accept;
   logic                  match;

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign match     = cmp_vld_ff && (rd_data == val_ff);

   always_comb begin
      state_in   = state_ff;
      head_in    = head_ff;
      tail_in    = tail_ff;
      count_in   = count_ff;
      scan_in    = scan_ff;
      cmp_vld_in = 1'b0;
      found_in   = found_ff;
      val_in     = val_ff;
      res_in     = res_ff;
      ram_req    = '0;
      push.valid = 1'b0;
      push.data  = res_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               val_in           = to_word(req_data.value);
               res_in.status    = STATUS_OK;
               res_in.found     = 1'b0;
               res_in.read_data = '0;
               state_in         = ST_DONE;
               unique case (req_data.operation)
                  OP_ENQUEUE: begin
                     if (count_ff >= CNT_W'(DEPTH)) begin
                        res_in.status = STATUS_FULL;
                     end else begin
                        ram_req.wr_en   = 1'b1;
                        ram_req.wr_addr = tail_ff;
                        ram_req.wr_data = to_word(req_data.value);
                        tail_in         = next_slot(tail_ff);
                        count_in        = count_ff + 1'b1;
                     end
                  end
                  OP_DEQUEUE: begin
                     if (count_ff == '0) begin
                        res_in.status = STATUS_EMPTY;
                     end else begin
                        head_in  = next_slot(head_ff);
                        count_in = count_ff - 1'b1;
                     end
                  end
                  OP_SEARCH: begin
                     if (count_ff != '0) begin
                        scan_in  = '0;
                        found_in = 1'b0;
                        state_in = ST_SEARCH;
                     end
                  end
                  OP_READ: begin
                     if (CMP_W'(req_data.position) >= CMP_W'(count_ff)) begin
                        res_in.status = STATUS_BAD_POS;
                     end else begin
                        ram_req.rd_en   = 1'b1;
                        ram_req.rd_addr = slot_at(head_ff, IDX_W'(req_data.position));
                        state_in        = ST_READ;
                     end
                  end
               endcase
               res_in.occupancy = 5'(count_in);
               res_in.is_empty  = (count_in == '0);
            end
         end
         ST_READ: begin
            res_in.read_data = to_out(rd_data);
            state_in         = ST_DONE;
         end
         ST_SEARCH: begin
            if (scan_ff != count_ff) begin
               ram_req.rd_en   = 1'b1;
               ram_req.rd_addr = slot_at(head_ff, scan_ff[IDX_W-1:0]);
               scan_in         = scan_ff + 1'b1;
               cmp_vld_in      = 1'b1;
            end
            found_in = found_ff | match;
            if ((scan_ff == count_ff) && cmp_vld_ff) begin
               res_in.found = found_in;
               state_in     = ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               push.valid = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         head_ff    <= '0;
         tail_ff    <= '0;
         count_ff   <= '0;
         cmp_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         head_ff    <= head_in;
         tail_ff    <= tail_in;
         count_ff   <= count_in;
         cmp_vld_ff <= cmp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      scan_ff  <= scan_in;
      found_ff <= found_in;
      val_ff   <= val_in;
      res_ff   <= res_in;
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("entry count exceeds depth");

   a_ring_empty: assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0) |-> (head_ff == tail_ff))
      else $error("head and tail differ on empty queue");

   a_write_idle: assert property (@(posedge clock) disable iff (reset)
      ram_req.wr_en |-> (state_ff == ST_IDLE) && accept)
      else $error("memory write outside an accepted enqueue");

   a_scan_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SEARCH) |-> (scan_ff <= count_ff))
      else $error("search index past entry count");

   a_push_free: assert property (@(posedge clock) disable iff (reset)
      push.valid |-> out_free && (state_ff == ST_DONE))
      else $error("result pushed into busy output register");

endmodule

@@ src/fifo_queue_with_search.sv @@
// bounded fifo queue of signed words with search and positional read
// req channel: req_valid, req_stall (driven here), req_data carries
//   operation, value and position; a transaction completes when req_valid
//   is high and req_stall is low at a rising clock edge
// rsp channel: rsp_valid, rsp_stall (driven by the receiver), rsp_data
//   carries status, found, read_data, is_empty and occupancy; one rsp
//   transaction per req transaction, in order
// entries live in a one-port-write, one-port-read ram with registered read
// one request at a time: enqueue and dequeue finish without a ram read, read at
//   position does one ram read, and search reads every held entry once
//   through the ram read port; a search of an empty queue reads no entry
// the finished result is passed into an output register that drives rsp,
//   so the next request can be worked on while it waits; when rsp_stall
//   is held a finished result waits and req_stall rises until the output
//   register frees
// reset clears head, tail and count so the queue starts empty; the ram
//   needs no clearing since only held entries are ever read
module fifo_queue_with_search
   import fqs_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   push_type              push;
   ram_req_type           ram_req;
   logic [DATA_WIDTH-1:0] rd_data;
   logic                  out_free;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_type               rsp_data_ff;

   assign out_free = !rsp_valid_ff || !rsp_stall;

   fqs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .out_free  (out_free),
      .push      (push),
      .ram_req   (ram_req),
      .rd_data   (rd_data)
   );

   fqs_ram u_ram (
      .clock   (clock),
      .ram_req (ram_req),
      .rd_data (rd_data)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (push.valid) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.valid) begin
         rsp_data_ff <= push.data;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

@@ dv/testbench.sv @@
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import fqs_pkg::*;

   localparam int LONG_HOLD      = 200;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int END_WAIT       = 40;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_stall;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_stall;
   rsp_type rsp_data;

   rsp_type               pending_results[$];
   logic [DATA_WIDTH-1:0] held_words[$];
   int                    mismatches = 0;
   int                    idle_cycles = 0;
   bit                    steady_flow = 1'b0;
   bit                    hold_rsp_long = 1'b0;

   fifo_queue_with_search i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic int idle_len();
      int r;
      if (steady_flow) begin
         return 0;
      end
      r = $urandom_range(0, 99);
      if (r < 55) begin
         return 0;
      end
      if (r < 85) begin
         return $urandom_range(1, 3);
      end
      if (r < 97) begin
         return $urandom_range(4, 12);
      end
      return $urandom_range(20, 60);
   endfunction

   function automatic req_type make_req(logic [1:0] op, logic [31:0] v, int pos);
      req_type r;
      r.operation = op;
      r.value     = v;
      r.position  = POS_W'(pos);
      return r;
   endfunction

   // expected result of one request, advancing the queue contents
   function automatic rsp_type predict_result(req_type r);
      rsp_type               o;
      logic [DATA_WIDTH-1:0] w;
      int                    pos;
      o        = '0;
      o.status = STATUS_OK;
      w        = DATA_WIDTH'(r.value);
      pos      = int'(r.position);
      case (r.operation)
         OP_ENQUEUE: begin
            if (held_words.size() >= DEPTH) begin
               o.status = STATUS_FULL;
            end else begin
               held_words.push_back(w);
            end
         end
         OP_DEQUEUE: begin
            if (held_words.size() == 0) begin
               o.status = STATUS_EMPTY;
            end else begin
               void'(held_words.pop_front());
            end
         end
         OP_SEARCH: begin
            foreach (held_words[i]) begin
               if (held_words[i] == w) begin
                  o.found = 1'b1;
               end
            end
         end
         OP_READ: begin
            if (pos >= held_words.size()) begin
               o.status = STATUS_BAD_POS;
            end else begin
               o.read_data = 32'(held_words[pos]);
            end
         end
      endcase
      o.is_empty  = (held_words.size() == 0);
      o.occupancy = 5'(held_words.size());
      return o;
   endfunction

   function automatic logic [31:0] pick_value();
      int r;
      r = $urandom_range(0, 99);
      if (r < 15) begin
         case ($urandom_range(0, 3))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'h0000_0000;
            default: return 32'hffff_ffff;
         endcase
      end
      if (r < 40 && held_words.size() > 0) begin
         return 32'(held_words[$urandom_range(0, held_words.size() - 1)]);
      end
      return $urandom();
   endfunction

   task automatic send_request(req_type r);
      int gap;
      gap = idle_len();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      do @(posedge clock); while (req_stall !== 1'b0);
      pending_results.push_back(predict_result(r));
   endtask

   task automatic wait_all_results();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_results.size() != 0);
   endtask

   task automatic check_field(string field, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
         mismatches++;
         $display("%0t: %s expected 0x%0h actual 0x%0h", $time, field, want, got);
      end
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         if (pending_results.size() == 0) begin
            mismatches++;
            $display("%0t: transaction expected none actual 0x%0h", $time, rsp_data);
         end else begin
            want = pending_results.pop_front();
            check_field("status", want.status, rsp_data.status);
            check_field("found", want.found, rsp_data.found);
            check_field("read_data", want.read_data, rsp_data.read_data);
            check_field("is_empty", want.is_empty, rsp_data.is_empty);
            check_field("occupancy", want.occupancy, rsp_data.occupancy);
         end
      end
   end

   // receiver stalls
   initial begin
      int n;
      rsp_stall = 1'b0;
      @(posedge clock);
      forever begin
         if (hold_rsp_long) begin
            n = LONG_HOLD;
            hold_rsp_long = 1'b0;
         end else begin
            n = idle_len();
         end
         if (n > 0) begin
            rsp_stall <= 1'b1;
            repeat (n) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         @(posedge clock);
      end
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   task automatic test_directed_cases();
      send_request(make_req(OP_DEQUEUE, $urandom(), 0));
      send_request(make_req(OP_SEARCH, 32'h0000_0000, 0));
      send_request(make_req(OP_READ, $urandom(), 0));
      send_request(make_req(OP_ENQUEUE, 32'h8000_0000, 0));
      send_request(make_req(OP_ENQUEUE, 32'h7fff_ffff, 0));
      send_request(make_req(OP_ENQUEUE, 32'h0000_0000, 0));
      send_request(make_req(OP_ENQUEUE, 32'hffff_ffff, 0));
      send_request(make_req(OP_SEARCH, 32'h7fff_ffff, 0));
      send_request(make_req(OP_SEARCH, 32'h0000_0001, 0));
      send_request(make_req(OP_SEARCH, 32'h8000_0000, 0));
      send_request(make_req(OP_READ, $urandom(), 0));
      send_request(make_req(OP_READ, $urandom(), 3));
      send_request(make_req(OP_READ, $urandom(), 4));
      send_request(make_req(OP_READ, $urandom(), 255));
      send_request(make_req(OP_DEQUEUE, $urandom(), 0));
      send_request(make_req(OP_READ, $urandom(), 0));
      send_request(make_req(OP_SEARCH, 32'h8000_0000, 0));
      repeat (3) send_request(make_req(OP_DEQUEUE, $urandom(), 0));
      send_request(make_req(OP_DEQUEUE, $urandom(), 0));
   endtask

   // fill past full while the receiver holds off, then drain to empty
   task automatic test_full_under_backpressure();
      logic [31:0] v;
      logic [31:0] last_v;
      last_v = '0;
      steady_flow   = 1'b1;
      hold_rsp_long = 1'b1;
      wait (!hold_rsp_long);
      for (int k = 0; k < DEPTH + 2; k++) begin
         v = $urandom();
         if (k == DEPTH - 1) begin
            last_v = v;
         end
         send_request(make_req(OP_ENQUEUE, v, $urandom_range(0, 255)));
      end
      steady_flow = 1'b0;
      send_request(make_req(OP_SEARCH, last_v, 0));
      send_request(make_req(OP_READ, $urandom(), DEPTH - 1));
      send_request(make_req(OP_READ, $urandom(), DEPTH));
      wait_all_results();
      for (int k = 0; k < DEPTH + 1; k++) begin
         send_request(make_req(OP_DEQUEUE, $urandom(), 0));
      end
      wait_all_results();
   endtask

   task automatic test_random_traffic(int n_items);
      logic [1:0] op;
      int         r;
      int         pos;
      bit         filling;
      filling = 1'b1;
      for (int k = 0; k < n_items; k++) begin
         if (k > 0 && k % 40 == 0) begin
            filling = !filling;
         end
         steady_flow = (k >= 200 && k < 300);
         r = $urandom_range(0, 99);
         if (filling) begin
            if (r < 50) op = OP_ENQUEUE;
            else if (r < 65) op = OP_DEQUEUE;
            else if (r < 85) op = OP_SEARCH;
            else op = OP_READ;
         end else begin
            if (r < 15) op = OP_ENQUEUE;
            else if (r < 55) op = OP_DEQUEUE;
            else if (r < 78) op = OP_SEARCH;
            else op = OP_READ;
         end
         if ($urandom_range(0, 99) < 80) begin
            pos = $urandom_range(0, held_words.size() + 1);
         end else begin
            pos = $urandom_range(0, 255);
         end
         send_request(make_req(op, pick_value(), pos));
         if (k % 125 == 124) begin
            wait_all_results();
         end
      end
      steady_flow = 1'b0;
   endtask

   initial begin
      reset     = 1'b1;
      req_valid = 1'b0;
      req_data  = '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      test_directed_cases();
      wait_all_results();
      test_full_under_backpressure();
      test_random_traffic(500);
      wait_all_results();
      repeat (END_WAIT) @(posedge clock);
      if (mismatches == 0 && pending_results.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

@@ sim.f @@
src/fqs_pkg.sv
src/fqs_ram.sv
src/fqs_ctrl.sv
src/fifo_queue_with_search.sv
dv/testbench.sv
